[rtl/core/brle_pkg.sv]
`timescale 1ns / 1ps

package brle_pkg;

  // bits scanned per input word; bits above the 32-bit field read as zero
  localparam int WORD_BITS = 32;
  localparam int CNT_W     = $clog2(WORD_BITS + 1);

  localparam int RUN_W     = 32;
  localparam int LEN_W     = RUN_W - 1;
  localparam logic [LEN_W-1:0] LEN_FULL = {LEN_W{1'b1}};

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [31:0] data_word;
    logic        end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [RUN_W-1:0] run_word;
    logic             final_run;
  } out_item_t;

endpackage

[rtl/core/bit_run_length_encoder.sv]
`timescale 1ns / 1ps
// Bit run-length encoder. Input words arrive on in_valid/in_stall/in_data,
// each 32 bits scanned MSB first plus an end_of_stream flag. Closed runs
// leave on out_valid/out_stall/out_data as run words: bit 31 the run value,
// bits 30..0 the length minus one; final_run marks the run flushed by the
// word flagged end_of_stream. A full length field closes the run early.
// A word is taken whenever valid is high and in_stall is low; a two-entry
// queue holds words while the scanner works.
// Timing: the scanner loads a word, then takes one segment of equal bits
// in it (1 to 32) per cycle while no closing step waits on out_stall, and
// adds a flush step at end of stream. The scan loop, one leading-bit count
// and length add per cycle, sets the pace. out_valid rises at the earliest
// with the first scan step after the word is loaded from the queue.
// Every step that closes a run waits while the output register is held by
// out_stall; the queue then fills and in_stall rises.
// Reset (synchronous, rst_n low) empties the queue, drops any open run and
// clears out_valid.

module bit_run_length_encoder
  import brle_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic     q_valid;
  logic     q_pop;
  in_item_t q_data;

  brle_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_pop    (q_pop),
    .q_valid  (q_valid),
    .q_data   (q_data)
  );

  brle_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[rtl/core/brle_queue.sv]
`timescale 1ns / 1ps

module brle_queue
  import brle_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     q_pop,
  output logic     q_valid,
  output in_item_t q_data
);

  in_item_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                push;
  logic                pop;

  assign in_stall = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_data   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= in_data;
    end
  end

endmodule

[rtl/core/brle_scan.sv]
`timescale 1ns / 1ps

module brle_scan
  import brle_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  in_item_t  q_data,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FLUSH} state_t;

  state_t               state_r, state_nxt;
  logic [WORD_BITS-1:0] sh_r, sh_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic                 eos_r, eos_nxt;
  logic                 run_open_r, run_open_nxt;
  logic                 prev_bit_r, prev_bit_nxt;
  logic [RUN_W-1:0]     acc_r, acc_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  logic                 cur_bit;
  logic [WORD_BITS-1:0] diff;
  logic [CNT_W-1:0]     lead;
  logic [CNT_W-1:0]     seg_len;
  logic [RUN_W-1:0]     len_sum;
  logic                 can_emit;

  assign cur_bit  = sh_r[WORD_BITS-1];
  assign diff     = sh_r ^ {WORD_BITS{cur_bit}};
  assign can_emit = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == ST_IDLE) && q_valid;

  // leading bits equal to the top bit; the highest differing bit wins
  always_comb begin
    lead = CNT_W'(WORD_BITS);
    for (int i = 0; i < WORD_BITS; i++) begin
      if (diff[i]) begin
        lead = CNT_W'(WORD_BITS - 1 - i);
      end
    end
  end

  assign seg_len = (lead < rem_r) ? lead : rem_r;
  // carry into bit 31 means the length field filled inside this segment
  assign len_sum = {1'b0, acc_r[LEN_W-1:0]} + RUN_W'(seg_len);

  always_comb begin
    logic emit;
    logic [RUN_W-1:0] emit_word;
    logic [RUN_W-1:0] new_acc;

    state_nxt     = state_r;
    sh_nxt        = sh_r;
    rem_nxt       = rem_r;
    eos_nxt       = eos_r;
    run_open_nxt  = run_open_r;
    prev_bit_nxt  = prev_bit_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    emit          = 1'b0;
    emit_word     = acc_r;
    new_acc       = {cur_bit, LEN_W'(seg_len) - 1'b1};

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          sh_nxt    = WORD_BITS'(q_data.data_word);
          rem_nxt   = CNT_W'(WORD_BITS);
          eos_nxt   = q_data.end_of_stream;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!run_open_r) begin
          emit = 1'b0;
        end else if (cur_bit == prev_bit_r) begin
          new_acc = {cur_bit, len_sum[LEN_W-1:0]};
          if (len_sum[RUN_W-1]) begin
            emit      = 1'b1;
            emit_word = {cur_bit, LEN_FULL};
          end
        end else begin
          emit = 1'b1;
        end
        if (!emit || can_emit) begin
          acc_nxt      = new_acc;
          run_open_nxt = 1'b1;
          prev_bit_nxt = cur_bit;
          sh_nxt       = sh_r << seg_len;
          rem_nxt      = rem_r - seg_len;
          if (emit) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{run_word: emit_word, final_run: 1'b0};
          end
          if (rem_r == seg_len) begin
            state_nxt = eos_r ? ST_FLUSH : ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{run_word: acc_r, final_run: 1'b1};
          run_open_nxt  = 1'b0;
          prev_bit_nxt  = 1'b0;
          acc_nxt       = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      run_open_r  <= 1'b0;
      prev_bit_r  <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_open_r  <= run_open_nxt;
      prev_bit_r  <= prev_bit_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
      sh_r        <= sh_nxt;
      rem_r       <= rem_nxt;
      eos_r       <= eos_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[verif/bit_run_length_encoder_test.sv]
`timescale 1ns / 1ps

module bit_run_length_encoder_test;
  import brle_pkg::*;

  localparam int CYCLE_LIMIT     = 1000000;
  localparam int WORDS_PER_PHASE = 65;
  localparam int DRAIN_CYCLES    = 40;
  localparam int PRINT_CAP       = 50;

  // Expected run words, worked out from every word the block takes.
  class run_scoreboard;
    logic        run_open  = 1'b0;
    logic        prev_bit  = 1'b0;
    logic [31:0] run_acc   = '0;
    out_item_t   expected_runs[$];
    int          mismatches = 0;

    task report(string msg);
      if (mismatches < PRINT_CAP) $display("mismatch: %s", msg);
      mismatches++;
    endtask

    function void push_run(logic [31:0] rw, logic fin);
      out_item_t e;
      e.run_word  = rw;
      e.final_run = fin;
      expected_runs.push_back(e);
    endfunction

    function void note_word(in_item_t w);
      int   j;
      logic cur_bit;
      for (j = WORD_BITS - 1; j >= 0; j--) begin
        // bits above the 32-bit field scan as zero
        cur_bit = (j < 32) ? w.data_word[j] : 1'b0;
        if (!run_open) begin
          run_acc  = {cur_bit, {LEN_W{1'b0}}};
          run_open = 1'b1;
        end else if (cur_bit == prev_bit && run_acc[LEN_W-1:0] != LEN_FULL) begin
          run_acc = run_acc + 32'd1;
        end else begin
          push_run(run_acc, 1'b0);
          run_acc = {cur_bit, {LEN_W{1'b0}}};
        end
        prev_bit = cur_bit;
      end
      if (w.end_of_stream) begin
        if (run_open) push_run(run_acc, 1'b1);
        run_open = 1'b0;
        prev_bit = 1'b0;
        run_acc  = '0;
      end
    endfunction

    task check_run(out_item_t got);
      out_item_t want;
      if (expected_runs.size() == 0) begin
        report($sformatf("unexpected run word %h final %b", got.run_word, got.final_run));
      end else begin
        want = expected_runs.pop_front();
        if (got.run_word !== want.run_word)
          report($sformatf("run_word %h, expected %h", got.run_word, want.run_word));
        if (got.final_run !== want.final_run)
          report($sformatf("final_run %b, expected %b (run %h)",
                           got.final_run, want.final_run, want.run_word));
      end
    endtask
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;

  run_scoreboard sb;

  always #2 clk = ~clk;

  bit_run_length_encoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side: check on accept, then pick the next stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_run(out_data);
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic in_item_t mk_word(logic [31:0] w, logic eos);
    in_item_t item;
    item.data_word     = w;
    item.end_of_stream = eos;
    return item;
  endfunction

  // present one word, hold it until taken
  task send_word(in_item_t item);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(item);
  endtask

  // one stream, mostly long runs as real bitmaps have
  task send_random_stream(output int sent);
    int          n;
    int          kind;
    int          pos;
    logic [31:0] w;
    logic        lvl;
    n   = ($urandom_range(7) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 5);
    lvl = 1'($urandom_range(1));
    for (int k = 0; k < n; k++) begin
      kind = $urandom_range(9);
      case (kind)
        0, 1, 2, 3: w = {32{lvl}};
        4: begin
          lvl = ~lvl;
          w   = {32{lvl}};
        end
        5, 6: begin
          pos = $urandom_range(1, 31);
          w   = {32{lvl}} ^ (32'hFFFF_FFFF >> pos);
          lvl = ~lvl;
        end
        7, 8: begin
          w   = $urandom;
          lvl = w[0];
        end
        default: begin
          w   = $urandom_range(1) ? 32'hAAAA_AAAA : 32'h5555_5555;
          lvl = w[0];
        end
      endcase
      send_word(mk_word(w, k == n - 1));
    end
    sent = n;
  endtask

  initial begin
    int sent;
    int total;
    sb = new;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: solid, alternating, edge bits, runs across words
    send_word(mk_word(32'h0000_0000, 1'b1));
    send_word(mk_word(32'hFFFF_FFFF, 1'b1));
    send_word(mk_word(32'hAAAA_AAAA, 1'b1));
    send_word(mk_word(32'h5555_5555, 1'b1));
    send_word(mk_word(32'h8000_0000, 1'b1));
    send_word(mk_word(32'h0000_0001, 1'b1));
    send_word(mk_word(32'h0000_0000, 1'b0));
    send_word(mk_word(32'h0000_0000, 1'b0));
    send_word(mk_word(32'h0000_0000, 1'b1));
    send_word(mk_word(32'hFFFF_FFFF, 1'b0));
    send_word(mk_word(32'hFFFF_FFFF, 1'b1));
    send_word(mk_word(32'hFFFF_0000, 1'b0));
    send_word(mk_word(32'h0000_FFFF, 1'b1));
    send_word(mk_word(32'h0000_0000, 1'b0));
    send_word(mk_word(32'hFFFF_FFFF, 1'b1));
    send_word(mk_word(32'h7FFF_FFFE, 1'b0));
    send_word(mk_word(32'hAAAA_AAAA, 1'b1));
    send_word(mk_word($urandom, 1'b1));

    // random streams under each idling mix
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      total = 0;
      while (total < WORDS_PER_PHASE) begin
        send_random_stream(sent);
        total += sent;
      end
    end
    in_valid <= 1'b0;

    while (sb.expected_runs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.expected_runs.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/brle_pkg.sv
rtl/core/brle_queue.sv
rtl/core/brle_scan.sv
rtl/core/bit_run_length_encoder.sv
verif/bit_run_length_encoder_test.sv
